// ===== rtl/lsd_pkg.sv =====
// shared types, codes and the access attribute table for the load/store decoder
package lsd_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_MEM     = 2'd0,
    ST_BRANCH  = 2'd1,
    ST_UNSUP   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // primary opcodes
  localparam logic [5:0] OP_BC       = 6'd16;
  localparam logic [5:0] OP_B        = 6'd18;
  localparam logic [5:0] OP_BRANCH   = 6'd19;
  localparam logic [5:0] OP_XFORM    = 6'd31;
  localparam logic [5:0] OP_DFORM_LO = 6'd32;
  localparam logic [5:0] OP_DFORM_HI = 6'd55;

  // extended opcode low field shared by all x-form loads and stores
  localparam logic [4:0] XO_LDST   = 5'd23;
  localparam logic [4:0] XO_GRP_LMW  = 5'd14;
  localparam logic [4:0] XO_GRP_STMW = 5'd15;
  localparam logic [4:0] XO_GRP_LAST = 5'd23;
  localparam logic [4:0] XO_GRP_GAP  = 5'd2;

  // mnemonic ids
  localparam logic [5:0] ID_XFORM_BASE = 6'd24;
  localparam logic [5:0] ID_B          = 6'd46;
  localparam logic [5:0] ID_BL         = 6'd47;
  localparam logic [5:0] ID_BC         = 6'd48;
  localparam logic [5:0] ID_BRANCH     = 6'd49;
  localparam logic [5:0] ID_OP31       = 6'd50;
  localparam logic [5:0] ID_UNKNOWN    = 6'd51;

  // access sizes that need store data masking
  localparam logic [7:0] SIZE_BYTE = 8'd1;
  localparam logic [7:0] SIZE_HALF = 8'd2;

  // number of registers, for the store multiple length
  localparam logic [5:0] NUM_GPR = 6'd32;

  // decode queue depth and derived widths
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // per-opcode access attributes
  typedef struct packed {
    logic       multi;
    logic       istore;
    logic       write;
    logic [3:0] size;
  } acc_attr_t;

  localparam int ACC_ENTRIES = 24;

  // indexed by primary opcode minus 32, or by x-form group
  localparam logic [6:0] ACC_TAB [ACC_ENTRIES] = '{
    7'h04, 7'h04, 7'h01, 7'h01, 7'h34, 7'h34, 7'h31, 7'h31,
    7'h02, 7'h02, 7'h02, 7'h02, 7'h32, 7'h32, 7'h04, 7'h54,
    7'h04, 7'h04, 7'h08, 7'h08, 7'h14, 7'h14, 7'h18, 7'h18
  };

  function automatic acc_attr_t acc_attr(input logic [4:0] k);
    acc_attr_t a;
    a = '0;
    if (k < 5'(ACC_ENTRIES)) begin
      a = acc_attr_t'(ACC_TAB[k]);
    end
    return a;
  endfunction

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  mnemonic_id;
    logic        is_write;
    logic [7:0]  xfer_bytes;
    logic [31:0] base_op;
    logic [31:0] offset;
    logic [4:0]  ra_num;
    logic        ra_used;
    logic [4:0]  rb_num;
    logic        rb_used;
    logic [4:0]  source_reg;
    logic [31:0] source_value;
    logic        store_valid;
  } dec_t;

endpackage

// ===== rtl/lsd_front.sv =====
// front end: classifies the instruction word and gathers address operands
module lsd_front
  import lsd_pkg::*;
(
  input  logic [31:0] instr_word,
  input  logic [31:0] base_value,
  input  logic [31:0] index_value,
  input  logic [31:0] source_value,
  output dec_t        dec
);

  logic [5:0]  primary;
  logic [4:0]  rt;
  logic [4:0]  ra;
  logic [4:0]  rb;
  logic [9:0]  xo;
  logic [4:0]  xgrp;
  logic [4:0]  xgrp_adj;
  logic        x_ok;
  logic        is_mem;
  logic        is_x;
  logic [4:0]  k_sel;
  logic [5:0]  mnem_mem;
  logic [31:0] offset;
  acc_attr_t   attr;

  assign primary  = instr_word[31:26];
  assign rt       = instr_word[25:21];
  assign ra       = instr_word[20:16];
  assign rb       = instr_word[15:11];
  assign xo       = instr_word[10:1];
  assign xgrp     = xo[9:5];
  assign xgrp_adj = (xgrp < XO_GRP_LMW) ? xgrp : (xgrp - XO_GRP_GAP);

  // x-form load/store groups, skipping the multiple-word slots
  assign x_ok = (xo[4:0] == XO_LDST) && (xgrp <= XO_GRP_LAST) &&
                (xgrp != XO_GRP_LMW) && (xgrp != XO_GRP_STMW);

  // primary opcode decode
  always_comb begin
    is_mem   = 1'b0;
    is_x     = 1'b0;
    k_sel    = '0;
    mnem_mem = '0;
    offset   = '0;
    dec      = '0;
    unique case (primary) inside
      OP_B: begin
        dec.status      = ST_BRANCH;
        dec.mnemonic_id = instr_word[0] ? ID_BL : ID_B;
      end
      OP_BC: begin
        dec.status      = ST_BRANCH;
        dec.mnemonic_id = ID_BC;
      end
      OP_BRANCH: begin
        dec.status      = ST_BRANCH;
        dec.mnemonic_id = ID_BRANCH;
      end
      [OP_DFORM_LO:OP_DFORM_HI]: begin
        is_mem   = 1'b1;
        k_sel    = primary[4:0];
        mnem_mem = {1'b0, primary[4:0]};
        offset   = {{16{instr_word[15]}}, instr_word[15:0]};
      end
      OP_XFORM: begin
        if (x_ok) begin
          is_mem   = 1'b1;
          is_x     = 1'b1;
          k_sel    = xgrp;
          mnem_mem = ID_XFORM_BASE + {1'b0, xgrp_adj};
          offset   = index_value;
        end else begin
          dec.status      = ST_UNSUP;
          dec.mnemonic_id = ID_OP31;
        end
      end
      default: begin
        dec.status      = ST_UNKNOWN;
        dec.mnemonic_id = ID_UNKNOWN;
      end
    endcase

    attr = acc_attr(k_sel);

    // memory access fields
    if (is_mem) begin
      dec.status       = ST_MEM;
      dec.mnemonic_id  = mnem_mem;
      dec.is_write     = attr.write;
      dec.xfer_bytes   = attr.multi ? {NUM_GPR - {1'b0, rt}, 2'b00} : {4'b0, attr.size};
      dec.base_op      = (ra != 5'd0) ? base_value : 32'd0;
      dec.offset       = offset;
      dec.ra_num       = ra;
      dec.ra_used      = (ra != 5'd0);
      dec.rb_num       = is_x ? rb : 5'd0;
      dec.rb_used      = is_x;
      dec.source_reg   = attr.istore ? rt : 5'd0;
      dec.source_value = source_value;
      dec.store_valid  = attr.istore;
    end
  end

endmodule

// ===== rtl/lsd_queue.sv =====
// short register queue between the decode front and the address back end
module lsd_queue
  import lsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  dec_t push_item,
  output logic pop_valid,
  input  logic pop_ready,
  output dec_t pop_item
);

  dec_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/lsd_back.sv =====
// back end: effective address add, store data masking and output register
module lsd_back
  import lsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  dec_t        item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  mnemonic_id,
  output logic        is_write,
  output logic [7:0]  xfer_bytes,
  output logic [31:0] eff_addr,
  output logic [4:0]  ra_num,
  output logic        ra_used,
  output logic [4:0]  rb_num,
  output logic        rb_used,
  output logic [4:0]  source_reg,
  output logic [31:0] store_value,
  output logic        store_value_valid
);

  logic        load;
  logic [31:0] ea_next;
  logic [31:0] store_next;

  assign item_ready = !out_valid || out_ready;
  assign load       = item_valid && item_ready;

  // address generation
  assign ea_next = item.base_op + item.offset;

  // store data masked to the access size
  always_comb begin
    store_next = '0;
    if (item.store_valid) begin
      case (item.xfer_bytes)
        SIZE_BYTE: store_next = {24'd0, item.source_value[7:0]};
        SIZE_HALF: store_next = {16'd0, item.source_value[15:0]};
        default:   store_next = item.source_value;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      status            <= item.status;
      mnemonic_id       <= item.mnemonic_id;
      is_write          <= item.is_write;
      xfer_bytes        <= item.xfer_bytes;
      eff_addr          <= ea_next;
      ra_num            <= item.ra_num;
      ra_used           <= item.ra_used;
      rb_num            <= item.rb_num;
      rb_used           <= item.rb_used;
      source_reg        <= item.source_reg;
      store_value       <= store_next;
      store_value_valid <= item.store_valid;
    end
  end

endmodule

// ===== rtl/load_store_decode_agu.sv =====
// top level of the load/store decoder and address generator
// Decodes one 32-bit instruction word per item into a branch, memory access,
// unsupported opcode-31 form or unknown opcode, and for memory accesses gives
// direction, size, effective address, register numbers and masked store data.
// An item is accepted every cycle while the two-entry decode queue has room;
// on acceptance it is written into the queue register and then, once the back
// end is ready, into the output register, where its result is held until it
// is taken. The decode front and the address back end are parted by the queue,
// so an output stall holds the back end while the front keeps taking items
// until the queue fills.
module load_store_decode_agu
  import lsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic [31:0] base_value,
  input  logic [31:0] index_value,
  input  logic [31:0] source_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [5:0]  mnemonic_id,
  output logic        is_write,
  output logic [7:0]  xfer_bytes,
  output logic [31:0] eff_addr,
  output logic [4:0]  ra_num,
  output logic        ra_used,
  output logic [4:0]  rb_num,
  output logic        rb_used,
  output logic [4:0]  source_reg,
  output logic [31:0] store_value,
  output logic        store_value_valid
);

  dec_t front_dec;
  dec_t q_item;
  logic q_valid;
  logic q_ready;

  // decode front
  lsd_front u_front (
    .instr_word   (instr_word),
    .base_value   (base_value),
    .index_value  (index_value),
    .source_value (source_value),
    .dec          (front_dec)
  );

  // decode queue
  lsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_dec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // address back end
  lsd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item              (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .mnemonic_id       (mnemonic_id),
    .is_write          (is_write),
    .xfer_bytes        (xfer_bytes),
    .eff_addr          (eff_addr),
    .ra_num            (ra_num),
    .ra_used           (ra_used),
    .rb_num            (rb_num),
    .rb_used           (rb_used),
    .source_reg        (source_reg),
    .store_value       (store_value),
    .store_value_valid (store_value_valid)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for the load/store decoder and address generator
`timescale 1ns / 100ps

module tb;
  import lsd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 150;

  // access groups: primary opcode minus 32, or the x-form extended opcode group
  typedef enum logic [4:0] {
    G_LWZ, G_LWZU, G_LBZ, G_LBZU, G_STW, G_STWU, G_STB, G_STBU,
    G_LHZ, G_LHZU, G_LHA, G_LHAU, G_STH, G_STHU, G_LMW, G_STMW,
    G_LFS, G_LFSU, G_LFD, G_LFDU, G_STFS, G_STFSU, G_STFD, G_STFDU
  } acc_grp_t;

  // one decoded result as seen on the output ports
  typedef struct packed {
    status_t     status;
    logic [5:0]  mnemonic_id;
    logic        is_write;
    logic [7:0]  xfer_bytes;
    logic [31:0] eff_addr;
    logic [4:0]  ra_num;
    logic        ra_used;
    logic [4:0]  rb_num;
    logic        rb_used;
    logic [4:0]  source_reg;
    logic [31:0] store_value;
    logic        store_value_valid;
  } decode_res_t;

  // expected decode results and their checks
  class ls_scoreboard;
    decode_res_t pending_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function decode_res_t predict_decode(logic [31:0] w, logic [31:0] b,
                                         logic [31:0] x, logic [31:0] s);
      decode_res_t r;
      logic [5:0]  prim;
      logic [4:0]  rt, ra, rb, grp;
      logic [31:0] base_eff, ea;
      logic [7:0]  size;
      logic [5:0]  id;
      logic        wr, int_st, multi, mem;
      r = '0;
      prim = w[31:26];
      rt = w[25:21];
      ra = w[20:16];
      rb = w[15:11];
      base_eff = (ra != 5'd0) ? b : 32'd0;
      mem = 1'b0;
      grp = '0;
      id = '0;
      ea = '0;
      if (prim == OP_B) begin
        r.status = ST_BRANCH;
        r.mnemonic_id = w[0] ? ID_BL : ID_B;
      end else if (prim == OP_BC) begin
        r.status = ST_BRANCH;
        r.mnemonic_id = ID_BC;
      end else if (prim == OP_BRANCH) begin
        r.status = ST_BRANCH;
        r.mnemonic_id = ID_BRANCH;
      end else if (prim >= OP_DFORM_LO && prim <= OP_DFORM_HI) begin
        // d-form: base plus sign-extended displacement
        mem = 1'b1;
        grp = 5'(prim - OP_DFORM_LO);
        id = {1'b0, grp};
        ea = base_eff + {{16{w[15]}}, w[15:0]};
      end else if (prim == OP_XFORM) begin
        grp = w[10:6];
        if (w[5:1] != XO_LDST || grp == XO_GRP_LMW || grp == XO_GRP_STMW ||
            grp > XO_GRP_LAST) begin
          r.status = ST_UNSUP;
          r.mnemonic_id = ID_OP31;
        end else begin
          // x-form: base plus index, ids skip the multiple-transfer groups
          mem = 1'b1;
          id = ID_XFORM_BASE + ((grp < XO_GRP_LMW) ? {1'b0, grp}
                                                     : {1'b0, grp - XO_GRP_GAP});
          ea = base_eff + x;
          r.rb_num = rb;
          r.rb_used = 1'b1;
        end
      end else begin
        r.status = ST_UNKNOWN;
        r.mnemonic_id = ID_UNKNOWN;
      end

      if (mem) begin
        // access attributes per group
        size = 8'd4;
        wr = 1'b0;
        int_st = 1'b0;
        multi = 1'b0;
        case (grp)
          G_LBZ, G_LBZU: size = 8'd1;
          G_STW, G_STWU: begin
            wr = 1'b1;
            int_st = 1'b1;
          end
          G_STB, G_STBU: begin
            size = 8'd1;
            wr = 1'b1;
            int_st = 1'b1;
          end
          G_LHZ, G_LHZU, G_LHA, G_LHAU: size = 8'd2;
          G_STH, G_STHU: begin
            size = 8'd2;
            wr = 1'b1;
            int_st = 1'b1;
          end
          G_STMW: begin
            wr = 1'b1;
            multi = 1'b1;
          end
          G_LFD, G_LFDU: size = 8'd8;
          G_STFS, G_STFSU: wr = 1'b1;
          G_STFD, G_STFDU: begin
            size = 8'd8;
            wr = 1'b1;
          end
          default: ;
        endcase
        r.status = ST_MEM;
        r.mnemonic_id = id;
        r.is_write = wr;
        r.xfer_bytes = multi ? (8'(NUM_GPR - {1'b0, rt}) << 2) : size;
        r.eff_addr = ea;
        r.ra_num = ra;
        r.ra_used = (ra != 5'd0);
        if (int_st) begin
          r.source_reg = rt;
          r.store_value = (size == SIZE_BYTE) ? {24'd0, s[7:0]} :
                          (size == SIZE_HALF) ? {16'd0, s[15:0]} : s;
          r.store_value_valid = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_item(logic [31:0] w, logic [31:0] b, logic [31:0] x,
                            logic [31:0] s);
      pending_q = {pending_q, predict_decode(w, b, x, s)};
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(decode_res_t got);
      decode_res_t want;
      if (pending_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending_q.pop_front();
      cmp_field("status", 32'(got.status), 32'(want.status));
      cmp_field("mnemonic_id", 32'(got.mnemonic_id), 32'(want.mnemonic_id));
      cmp_field("is_write", 32'(got.is_write), 32'(want.is_write));
      cmp_field("xfer_bytes", 32'(got.xfer_bytes), 32'(want.xfer_bytes));
      cmp_field("eff_addr", got.eff_addr, want.eff_addr);
      cmp_field("ra_num", 32'(got.ra_num), 32'(want.ra_num));
      cmp_field("ra_used", 32'(got.ra_used), 32'(want.ra_used));
      cmp_field("rb_num", 32'(got.rb_num), 32'(want.rb_num));
      cmp_field("rb_used", 32'(got.rb_used), 32'(want.rb_used));
      cmp_field("source_reg", 32'(got.source_reg), 32'(want.source_reg));
      cmp_field("store_value", got.store_value, want.store_value);
      cmp_field("store_value_valid", 32'(got.store_value_valid),
                32'(want.store_value_valid));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] instr_word;
  logic [31:0] base_value;
  logic [31:0] index_value;
  logic [31:0] source_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [5:0]  mnemonic_id;
  logic        is_write;
  logic [7:0]  xfer_bytes;
  logic [31:0] eff_addr;
  logic [4:0]  ra_num;
  logic        ra_used;
  logic [4:0]  rb_num;
  logic        rb_used;
  logic [4:0]  source_reg;
  logic [31:0] store_value;
  logic        store_value_valid;

  ls_scoreboard sb = new();
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;

  load_store_decode_agu dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .instr_word        (instr_word),
    .base_value        (base_value),
    .index_value       (index_value),
    .source_value      (source_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .mnemonic_id       (mnemonic_id),
    .is_write          (is_write),
    .xfer_bytes        (xfer_bytes),
    .eff_addr          (eff_addr),
    .ra_num            (ra_num),
    .ra_used           (ra_used),
    .rb_num            (rb_num),
    .rb_used           (rb_used),
    .source_reg        (source_reg),
    .store_value       (store_value),
    .store_value_valid (store_value_valid)
  );

  // clock
  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side ready, with random stalls and one long hold-off
  always begin
    @(negedge clk);
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // capture each accepted result
  always @(posedge clk) begin
    decode_res_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.status = status_t'(status);
      got.mnemonic_id = mnemonic_id;
      got.is_write = is_write;
      got.xfer_bytes = xfer_bytes;
      got.eff_addr = eff_addr;
      got.ra_num = ra_num;
      got.ra_used = ra_used;
      got.rb_num = rb_num;
      got.rb_used = rb_used;
      got.source_reg = source_reg;
      got.store_value = store_value;
      got.store_value_valid = store_value_valid;
      sb.check_result(got);
    end
  end

  function automatic logic [31:0] dform_word(acc_grp_t g, logic [4:0] rt,
                                             logic [4:0] ra, logic [15:0] imm);
    return {OP_DFORM_LO + {1'b0, g}, rt, ra, imm};
  endfunction

  function automatic logic [31:0] xform_word(logic [4:0] g, logic [4:0] rt,
                                             logic [4:0] ra, logic [4:0] rb,
                                             logic [4:0] low, logic rc);
    return {OP_XFORM, rt, ra, rb, g, low, rc};
  endfunction

  // operand with a bias toward the extremes
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_ra();
    return ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom_range(31));
  endfunction

  // random instruction word, mostly well-formed memory accesses
  function automatic logic [31:0] rand_instr();
    int pick;
    logic [4:0] g;
    pick = $urandom_range(99);
    if (pick < 35) begin
      return dform_word(acc_grp_t'($urandom_range(23)), 5'($urandom),
                        rand_ra(), 16'($urandom));
    end else if (pick < 65) begin
      g = 5'($urandom_range(21));
      if (g >= XO_GRP_LMW) g = g + XO_GRP_GAP;
      return xform_word(g, 5'($urandom), rand_ra(), 5'($urandom), XO_LDST,
                        1'($urandom));
    end else if (pick < 75) begin
      case ($urandom_range(2))
        0: return {OP_B, 26'($urandom)};
        1: return {OP_BC, 26'($urandom)};
        default: return {OP_BRANCH, 26'($urandom)};
      endcase
    end else if (pick < 85) begin
      return {OP_XFORM, 26'($urandom)};
    end else begin
      return $urandom;
    end
  endfunction

  // offer one item and hold it until accepted; called at a falling edge
  task automatic send_item(logic [31:0] w, logic [31:0] b, logic [31:0] x,
                           logic [31:0] s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    instr_word = w;
    base_value = b;
    index_value = x;
    source_value = s;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(w, b, x, s);
    @(negedge clk);
  endtask

  // directed corner cases
  task automatic run_directed();
    send_item({OP_B, 26'h155_5554}, $urandom, $urandom, $urandom);
    send_item({OP_B, 26'h3FF_FFFF}, $urandom, $urandom, $urandom);
    send_item({OP_BC, 26'h234_5678}, $urandom, $urandom, $urandom);
    send_item({OP_BRANCH, 26'h3FF_FFFF}, $urandom, $urandom, $urandom);
    // base ignored when ra is zero
    send_item(dform_word(G_LWZ, 5'd0, 5'd0, 16'h7FFF), 32'hFFFF_FFFF, 0, 0);
    // negative displacement
    send_item(dform_word(G_LBZU, 5'd31, 5'd31, 16'h8000), 32'h0, 0, 0);
    send_item(dform_word(G_STW, 5'd31, 5'd1, 16'hFFFF), 32'h0, 0, 32'hFFFF_FFFF);
    send_item(dform_word(G_STB, 5'd5, 5'd3, 16'h0010), 32'h1000, 0, 32'hA5A5_5AC3);
    send_item(dform_word(G_STH, 5'd0, 5'd2, 16'h0002), 32'h8000_0000, 0,
              32'hFFFF_FFFF);
    send_item(dform_word(G_LHA, 5'd7, 5'd9, 16'h1234), 32'h7FFF_FFFF, 0, 0);
    send_item(dform_word(G_LMW, 5'd0, 5'd4, 16'h0000), 32'h100, 0, 32'h55);
    // store multiple length extremes
    send_item(dform_word(G_STMW, 5'd0, 5'd4, 16'h0000), 32'h100, 0, 32'h55);
    send_item(dform_word(G_STMW, 5'd31, 5'd4, 16'hFFFC), 32'h100, 0, 32'h55);
    send_item(dform_word(G_STFDU, 5'd8, 5'd1, 16'h0008), 32'h2000, 0, 32'hDEAD_BEEF);
    send_item(dform_word(G_LFS, 5'd1, 5'd0, 16'hFFF0), 32'h5, 0, 0);
    send_item(xform_word(G_LBZ, 5'd2, 5'd0, 5'd31, XO_LDST, 1'b0), 32'h1234,
              32'hFFFF_FFFF, 0);
    // address wraps past the top
    send_item(xform_word(G_STWU, 5'd3, 5'd31, 5'd1, XO_LDST, 1'b0), 32'hFFFF_FFFF,
              32'h1, 32'h8000_0001);
    send_item(xform_word(G_STH, 5'd4, 5'd5, 5'd6, XO_LDST, 1'b1), 32'h10, 32'h20,
              32'h1234_ABCD);
    send_item(xform_word(G_STB, 5'd31, 5'd31, 5'd31, XO_LDST, 1'b0), 32'h0,
              32'h0, 32'hFFFF_FFFF);
    send_item(xform_word(G_STFDU, 5'd9, 5'd10, 5'd11, XO_LDST, 1'b1), 32'h40,
              32'h80, 32'h1);
    // opcode-31 forms outside the table
    send_item(xform_word(XO_GRP_LMW, 5'd1, 5'd1, 5'd1, XO_LDST, 1'b0), 1, 1, 1);
    send_item(xform_word(XO_GRP_STMW, 5'd1, 5'd1, 5'd1, XO_LDST, 1'b0), 1, 1, 1);
    send_item(xform_word(XO_GRP_LAST + 5'd1, 5'd1, 5'd1, 5'd1, XO_LDST, 1'b1),
              1, 1, 1);
    send_item(xform_word(G_LBZ, 5'd1, 5'd1, 5'd1, XO_LDST - 5'd1, 1'b0), 1, 1, 1);
    // unknown primary opcodes
    send_item(32'h0000_0000, 0, 0, 0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    instr_word = '0;
    base_value = '0;
    index_value = '0;
    source_value = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    run_directed();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stretch with no idling on either side
      calm = (n >= 300 && n < 420);
      // long output stall while items keep coming
      if (n == 500) hold_left = HOLD_CYCLES;
      // sender pause until all results are back
      if (n == 650) begin
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      send_item(rand_instr(), rand_operand(), rand_operand(), rand_operand());
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
